// ----- rtl/arrl_pkg.sv -----
// Shared types and constants for the address range reverse lookup block.
`default_nettype none
package arrl_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int ID_BITS       = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OWNER_W       = (ID_BITS < 32) ? ID_BITS : 32;

    // Scan pipeline: read, subtract, compare, then merge into the running best.
    localparam int PIPE_DEPTH    = 3;
    localparam int SCAN_LAST     = TABLE_ENTRIES - 1 + PIPE_DEPTH;
    localparam int CNT_W         = $clog2(SCAN_LAST + 1);

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } t_ctl_cmd;

endpackage
`default_nettype wire

// ----- rtl/arrl_ctrl.sv -----
// Controller state machine that sequences the table scan for each request.
`default_nettype none
module arrl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output arrl_pkg::t_ctl_cmd     o_cmd
);
    import arrl_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and scan counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCAN_LAST)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_idx = r_cnt[IDX_W-1:0];
        busy         = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SCAN: begin
                o_cmd.issue = (r_cnt < CNT_W'(TABLE_ENTRIES));
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // The finish step always returns to idle.
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after finish");

endmodule
`default_nettype wire

// ----- rtl/arrl_datapath.sv -----
// Table storage, pipelined range compare and result selection.
`default_nettype none
module arrl_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire arrl_pkg::t_ctl_cmd i_cmd,
    input  wire logic [1:0]         i_kind,
    input  wire logic [63:0]        i_address,
    input  wire logic [31:0]        i_owner_id,
    input  wire logic [63:0]        i_range_size,
    input  wire logic [63:0]        i_min_size,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [31:0]             o_match_id,
    output logic [1:0]              o_status
);
    import arrl_pkg::*;

    // Table memories; contents are only meaningful where the valid bit is set.
    logic [63:0]        mem_start [TABLE_ENTRIES];
    logic [OWNER_W-1:0] mem_owner [TABLE_ENTRIES];
    logic [63:0]        mem_size  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    // Latched request.
    t_kind              r_kind;
    logic [63:0]        r_addr, r_size, r_need;
    logic [OWNER_W-1:0] r_owner;

    // Pipeline stage 1: read data.
    logic               r_s1_vld, r_s1_ev;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [63:0]        r_s1_start, r_s1_size;
    logic [OWNER_W-1:0] r_s1_owner;

    // Pipeline stage 2: offset and key match.
    logic               r_s2_vld, r_s2_ev, r_s2_le, r_s2_pair;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [63:0]        r_s2_off, r_s2_size, r_s2_start;
    logic [OWNER_W-1:0] r_s2_owner;

    // Pipeline stage 3: coverage decision.
    logic               r_s3_vld, r_s3_hit, r_s3_pair, r_s3_free;
    logic [IDX_W-1:0]   r_s3_idx;
    logic [63:0]        r_s3_start;
    logic [OWNER_W-1:0] r_s3_owner;

    // Running results of the scan.
    logic               r_best_vld, r_pair_vld, r_free_vld;
    logic [63:0]        r_best_start;
    logic [OWNER_W-1:0] r_best_owner;
    logic [IDX_W-1:0]   r_pair_idx, r_free_idx;

    // Outputs.
    logic               r_out_vld, r_found;
    logic [31:0]        r_match_id;
    t_status            r_status;

    // Finish decisions.
    logic               n_wr_en, n_clr_en, n_found;
    logic [IDX_W-1:0]   n_wr_idx;
    t_status            n_status;
    logic [64:0]        s2_end;

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_addr  <= i_address;
            r_owner <= i_owner_id[OWNER_W-1:0];
            r_size  <= i_range_size;
            r_need  <= i_min_size;
        end
    end

    // Stage 1: synchronous memory read and valid bit lookup.
    always_ff @(posedge i_clk) begin
        r_s1_start <= mem_start[i_cmd.rd_idx];
        r_s1_owner <= mem_owner[i_cmd.rd_idx];
        r_s1_size  <= mem_size[i_cmd.rd_idx];
        r_s1_ev    <= r_valid[i_cmd.rd_idx];
        r_s1_idx   <= i_cmd.rd_idx;
    end

    // Stage 2: start compare, offset and start/owner key match.
    always_ff @(posedge i_clk) begin
        r_s2_le    <= (r_s1_start <= r_addr);
        r_s2_off   <= r_addr - r_s1_start;
        r_s2_pair  <= r_s1_ev && (r_s1_start == r_addr) && (r_s1_owner == r_owner);
        r_s2_ev    <= r_s1_ev;
        r_s2_idx   <= r_s1_idx;
        r_s2_size  <= r_s1_size;
        r_s2_start <= r_s1_start;
        r_s2_owner <= r_s1_owner;
    end

    // Offset plus needed bytes, exact in 65 bits.
    assign s2_end = {1'b0, r_s2_off} + {1'b0, r_need};

    // Stage 3: the range holds the address with enough bytes left.
    always_ff @(posedge i_clk) begin
        r_s3_hit   <= r_s2_ev && r_s2_le && (r_s2_off < r_s2_size)
                      && (s2_end <= {1'b0, r_s2_size});
        r_s3_pair  <= r_s2_pair;
        r_s3_free  <= !r_s2_ev;
        r_s3_idx   <= r_s2_idx;
        r_s3_start <= r_s2_start;
        r_s3_owner <= r_s2_owner;
    end

    // Stage tags and running results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_pair_vld <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (i_cmd.load) begin
                r_best_vld <= 1'b0;
                r_pair_vld <= 1'b0;
                r_free_vld <= 1'b0;
            end else if (r_s3_vld) begin
                if (r_s3_hit && (!r_best_vld || (r_s3_start > r_best_start)
                    || ((r_s3_start == r_best_start) && (r_s3_owner < r_best_owner)))) begin
                    r_best_vld <= 1'b1;
                end
                if (r_s3_pair && !r_pair_vld) begin
                    r_pair_vld <= 1'b1;
                end
                if (r_s3_free && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
            end
        end
    end

    // Payload of the running results.
    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            if (r_s3_hit && (!r_best_vld || (r_s3_start > r_best_start)
                || ((r_s3_start == r_best_start) && (r_s3_owner < r_best_owner)))) begin
                r_best_start <= r_s3_start;
                r_best_owner <= r_s3_owner;
            end
            if (r_s3_pair && !r_pair_vld) begin
                r_pair_idx <= r_s3_idx;
            end
            if (r_s3_free && !r_free_vld) begin
                r_free_idx <= r_s3_idx;
            end
        end
    end

    // Decide the outcome of the request once the scan has drained.
    always_comb begin
        n_wr_en  = 1'b0;
        n_clr_en = 1'b0;
        n_found  = 1'b0;
        n_wr_idx = r_pair_idx;
        n_status = ST_INVALID;
        case (r_kind)
            KIND_ADD: begin
                if ((r_owner != '0) && (r_size != '0) && (r_addr != '0)) begin
                    if (r_pair_vld) begin
                        n_wr_en  = 1'b1;
                        n_status = ST_DONE;
                    end else if (r_free_vld) begin
                        n_wr_en  = 1'b1;
                        n_wr_idx = r_free_idx;
                        n_status = ST_DONE;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            KIND_LOOKUP: begin
                if (r_addr != '0) begin
                    n_found  = r_best_vld;
                    n_status = r_best_vld ? ST_DONE : ST_ABSENT;
                end
            end
            KIND_REMOVE: begin
                n_clr_en = r_pair_vld;
                n_status = r_pair_vld ? ST_DONE : ST_ABSENT;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // Table memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && n_wr_en) begin
            mem_start[n_wr_idx] <= r_addr;
            mem_owner[n_wr_idx] <= r_owner;
            mem_size[n_wr_idx]  <= r_size;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish) begin
            if (n_wr_en) begin
                r_valid[n_wr_idx] <= 1'b1;
            end else if (n_clr_en) begin
                r_valid[r_pair_idx] <= 1'b0;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.finish;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found    <= n_found;
            r_match_id <= n_found ? 32'(r_best_owner) : 32'd0;
            r_status   <= n_status;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_found    = r_found;
    assign o_match_id = r_match_id;
    assign o_status   = r_status;

    // A result appears only in the cycle after a finish step.
    a_strobe_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.finish))
        else $error("result strobe without a finished request");

    // A hit always reports success.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_DONE))
        else $error("hit reported with a failure status");

    // A miss carries no owner id.
    a_miss_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_id == 32'd0))
        else $error("miss reported with a nonzero owner id");

endmodule
`default_nettype wire

// ----- rtl/address_range_reverse_lookup.sv -----
// Top level of the address range reverse lookup table.
// Each request scans all 64 table entries through a 3-stage compare pipeline.
// Requests do not overlap: a new one is accepted only once the controller is idle again.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous active-low reset clears all valid bits and the controller.
`default_nettype none
module address_range_reverse_lookup (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_address,
    input  wire logic [31:0] i_owner_id,
    input  wire logic [63:0] i_range_size,
    input  wire logic [63:0] i_min_size,
    output logic             o_valid,
    output logic             o_found,
    output logic [31:0]      o_match_id,
    output logic [1:0]       o_status
);
    import arrl_pkg::*;

    t_ctl_cmd cmd;

    // Scan sequencer.
    arrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Table and compare pipeline.
    arrl_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_owner_id   (i_owner_id),
        .i_range_size (i_range_size),
        .i_min_size   (i_min_size),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_match_id   (o_match_id),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

// ----- tb/address_range_reverse_lookup_tb.sv -----
// Self-checking testbench for the address range reverse lookup table.
`default_nettype none
module address_range_reverse_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arrl_pkg::*;

    // The request kind that the block leaves unused.
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam int          REPLY_LATENCY = 68;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [31:0] OWNER_MASK    =
        (ID_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ID_BITS) - 64'd1);
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        found;
        logic [31:0] match_id;
        t_status     status;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = KIND_ADD;
    logic [63:0] i_address = '0;
    logic [31:0] i_owner_id = '0;
    logic [63:0] i_range_size = '0;
    logic [63:0] i_min_size = '0;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_match_id;
    logic [1:0]  o_status;

    // Predicted contents of the range table.
    logic        tbl_valid [TABLE_ENTRIES];
    logic [63:0] tbl_start [TABLE_ENTRIES];
    logic [31:0] tbl_owner [TABLE_ENTRIES];
    logic [63:0] tbl_size  [TABLE_ENTRIES];

    t_reply      pending_replies[$];
    t_reply      want;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          burst_mode = 1'b0;
    logic [63:0] pool_start [16];

    address_range_reverse_lookup dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_owner_id   (i_owner_id),
        .i_range_size (i_range_size),
        .i_min_size   (i_min_size),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_match_id   (o_match_id),
        .o_status     (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     pending_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int find_pair(logic [63:0] addr, logic [31:0] owner);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_start[i] == addr && tbl_owner[i] == owner)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i])
                return i;
        end
        return -1;
    endfunction

    // True when entry i holds addr with at least need bytes left; no 64-bit wrap.
    function automatic bit entry_covers(int i, logic [63:0] addr, logic [63:0] need);
        logic [63:0] off;
        if (tbl_start[i] > addr)
            return 1'b0;
        off = addr - tbl_start[i];
        if (off >= tbl_size[i])
            return 1'b0;
        return need <= tbl_size[i] - off;
    endfunction

    // Apply one request to the predicted table and return the reply it should produce.
    function automatic t_reply apply_range_request(logic [1:0] kind, logic [63:0] addr,
                                                   logic [31:0] owner_in,
                                                   logic [63:0] size, logic [63:0] need);
        t_reply      r;
        int          slot;
        int          best;
        logic [31:0] owner;
        owner      = owner_in & OWNER_MASK;
        r.found    = 1'b0;
        r.match_id = '0;
        r.status   = ST_INVALID;
        case (kind)
            KIND_ADD: begin
                if (owner != 0 && size != 0 && addr != 0) begin
                    slot = find_pair(addr, owner);
                    if (slot < 0)
                        slot = first_free_slot();
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_valid[slot] = 1'b1;
                        tbl_start[slot] = addr;
                        tbl_owner[slot] = owner;
                        tbl_size[slot]  = size;
                        r.status        = ST_DONE;
                    end
                end
            end
            KIND_LOOKUP: begin
                if (addr != 0) begin
                    best = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!tbl_valid[i] || !entry_covers(i, addr, need))
                            continue;
                        if (best < 0 || tbl_start[i] > tbl_start[best] ||
                            (tbl_start[i] == tbl_start[best] &&
                             tbl_owner[i] < tbl_owner[best]))
                            best = i;
                    end
                    if (best >= 0) begin
                        r.found    = 1'b1;
                        r.match_id = tbl_owner[best];
                        r.status   = ST_DONE;
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
            end
            KIND_REMOVE: begin
                slot = find_pair(addr, owner);
                if (slot >= 0) begin
                    tbl_valid[slot] = 1'b0;
                    r.status        = ST_DONE;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Pick a random occupied entry, or -1 when the table is empty.
    function automatic int pick_valid_entry();
        int used;
        int nth;
        used = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i])
                used++;
        if (used == 0)
            return -1;
        nth = $urandom_range(0, used - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (nth == 0)
                    return i;
                nth--;
            end
        end
        return -1;
    endfunction

    // Drive one request after a random gap and record its reply once accepted.
    task automatic send_request(input logic [1:0] kind, input logic [63:0] addr,
                                input logic [31:0] owner, input logic [63:0] size,
                                input logic [63:0] need);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_address    <= addr;
        i_owner_id   <= owner;
        i_range_size <= size;
        i_min_size   <= need;
        do @(posedge i_clk); while (busy);
        pending_replies.push_back(apply_range_request(kind, addr, owner, size, need));
    endtask

    // Hold off new requests until every outstanding reply has arrived.
    task automatic wait_for_replies(input int tail);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    // Compare each reply with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected reply found=%0b id=%h status=%0d", $time,
                         o_found, o_match_id, o_status);
            end else begin
                want = pending_replies.pop_front();
                if (o_found !== want.found) begin
                    error_count++;
                    $display("%0t: found expected %0b actual %0b", $time,
                             want.found, o_found);
                end
                if (o_match_id !== want.match_id) begin
                    error_count++;
                    $display("%0t: match_id expected %h actual %h", $time,
                             want.match_id, o_match_id);
                end
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                end
            end
        end
    end

    // Lookup aimed inside an existing range, with min_size around the bytes left; else near a pool start.
    task automatic send_targeted_lookup();
        int          i;
        logic [63:0] span;
        logic [63:0] off;
        logic [63:0] rem;
        logic [63:0] need;
        i = pick_valid_entry();
        if (i < 0 || $urandom_range(0, 6) == 0) begin
            off = 64'($urandom_range(0, 64)) - 64'd32;
            send_request(KIND_LOOKUP, pool_start[$urandom_range(0, 15)] + off, $urandom,
                         rand64(), 64'($urandom_range(0, 16)));
            return;
        end
        span = (tbl_size[i] - 1 < ~tbl_start[i]) ? tbl_size[i] - 1 : ~tbl_start[i];
        case ($urandom_range(0, 3))
            0: off = '0;
            1: off = span;
            default: off = (span == ALL_ONES) ? rand64() : rand64() % (span + 1);
        endcase
        rem = tbl_size[i] - off;
        case ($urandom_range(0, 3))
            0: need = '0;
            1: need = rem;
            2: need = (rem == ALL_ONES) ? rem : rem + 1;
            default: need = (rem == ALL_ONES) ? rand64() : rand64() % (rem + 1);
        endcase
        send_request(KIND_LOOKUP, tbl_start[i] + off, $urandom, rand64(), need);
    endtask

    function automatic logic [31:0] pick_owner();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom | 32'd1;
            default: return 32'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [63:0] pick_size();
        case ($urandom_range(0, 9))
            0: return ALL_ONES;
            1: return rand64() | 64'd1;
            2, 3, 4: return 64'($urandom_range(1, 32'h10000));
            default: return 64'($urandom_range(1, 32'h400));
        endcase
    endfunction

    // Malformed arguments and the unused kind are rejected; lookups and removes that miss report absent.
    task automatic test_invalid_arguments();
        send_request(KIND_ADD, 64'h1000, 32'd0, 64'h100, 64'd0);
        send_request(KIND_ADD, 64'h1000, 32'd5, 64'd0, 64'd0);
        send_request(KIND_ADD, 64'd0, 32'd5, 64'h100, 64'd0);
        send_request(KIND_LOOKUP, 64'd0, 32'd5, 64'h100, 64'd0);
        send_request(KIND_UNUSED, rand64(), $urandom, rand64(), rand64());
        send_request(KIND_LOOKUP, 64'd5, 32'd0, 64'd0, 64'd0);
        send_request(KIND_REMOVE, 64'h1000, 32'd5, 64'd0, 64'd0);
        send_request(KIND_REMOVE, 64'd0, 32'd0, 64'd0, 64'd0);
    endtask

    // Overlapping ranges: descending start wins, then ascending owner; size update.
    task automatic test_overlap_priority();
        send_request(KIND_ADD, 64'h1000, 32'd7, 64'h100, 64'd0);
        send_request(KIND_ADD, 64'h1000, 32'd3, 64'h200, 64'd0);
        send_request(KIND_ADD, 64'h1080, 32'd9, 64'h40, 64'd0);
        send_request(KIND_LOOKUP, 64'h1090, 32'd0, 64'd0, 64'd0);
        send_request(KIND_LOOKUP, 64'h1090, 32'd0, 64'd0, 64'h40);
        send_request(KIND_LOOKUP, 64'h10F0, 32'd0, 64'd0, 64'h20);
        send_request(KIND_ADD, 64'h1000, 32'd3, 64'h10, 64'd0);
        send_request(KIND_LOOKUP, 64'h10F0, 32'd0, 64'd0, 64'h10);
        send_request(KIND_LOOKUP, 64'h1100, 32'd0, 64'd0, 64'd0);
    endtask

    // Ranges that reach the top of the address space must not wrap.
    task automatic test_address_extremes();
        send_request(KIND_ADD, 64'd1, 32'hFFFF_FFFF, ALL_ONES, 64'd0);
        send_request(KIND_LOOKUP, ALL_ONES, 32'd0, 64'd0, 64'd1);
        send_request(KIND_LOOKUP, ALL_ONES, 32'd0, 64'd0, 64'd2);
        send_request(KIND_ADD, ALL_ONES, 32'd1, ALL_ONES, 64'd0);
        send_request(KIND_LOOKUP, ALL_ONES, 32'd0, 64'd0, ALL_ONES);
        send_request(KIND_LOOKUP, 64'd1, 32'd0, 64'd0, ALL_ONES);
        send_request(KIND_REMOVE, 64'd1, 32'hFFFF_FFFF, 64'd0, 64'd0);
        send_request(KIND_REMOVE, 64'd1, 32'hFFFF_FFFF, 64'd0, 64'd0);
    endtask

    // Fill every entry, overflow it, update in place, then empty it again.
    task automatic test_table_full();
        int i;
        while (first_free_slot() >= 0)
            send_request(KIND_ADD, rand64() | 64'd1, $urandom | 32'd1, pick_size(), 64'd0);
        repeat (3)
            send_request(KIND_ADD, rand64() | 64'd1, $urandom | 32'd1, pick_size(), 64'd0);
        i = pick_valid_entry();
        send_request(KIND_ADD, tbl_start[i], tbl_owner[i], pick_size(), 64'd0);
        repeat (8)
            send_targeted_lookup();
        i = pick_valid_entry();
        while (i >= 0) begin
            send_request(KIND_REMOVE, tbl_start[i], tbl_owner[i], rand64(), rand64());
            i = pick_valid_entry();
        end
    endtask

    // Mixed traffic over a small pool of starts and owners, plus raw noise.
    task automatic test_random_traffic(input int count, input int add_pct, input int rm_pct);
        int          r;
        int          i;
        logic [63:0] base;
        base = rand64() >> $urandom_range(0, 40);
        for (int k = 0; k < 8; k++)
            pool_start[k] = base + 64'(k) * 64'h180;
        for (int k = 8; k < 12; k++)
            pool_start[k] = rand64();
        pool_start[12] = 64'd1;
        pool_start[13] = ALL_ONES;
        pool_start[14] = rand64() >> 1;
        pool_start[15] = ALL_ONES - 64'h200;
        for (int k = 0; k < 16; k++)
            if (pool_start[k] == 0)
                pool_start[k] = 64'h40;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0)
                burst_mode = !burst_mode;
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                send_request(KIND_ADD, pool_start[$urandom_range(0, 15)], pick_owner(),
                             pick_size(), rand64());
            end else if (r < add_pct + rm_pct) begin
                i = pick_valid_entry();
                if (i >= 0 && $urandom_range(0, 3) != 0)
                    send_request(KIND_REMOVE, tbl_start[i], tbl_owner[i], rand64(), rand64());
                else
                    send_request(KIND_REMOVE, pool_start[$urandom_range(0, 15)], pick_owner(),
                                 rand64(), rand64());
            end else if (r < 92) begin
                send_targeted_lookup();
            end else begin
                send_request(2'($urandom_range(0, 3)),
                             ($urandom_range(0, 4) == 0) ? 64'd0 : rand64(),
                             ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom,
                             ($urandom_range(0, 4) == 0) ? 64'd0 : rand64(), rand64());
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_owner[i] = '0;
            tbl_size[i]  = '0;
        end
        // Random starts for the early lookups that miss on purpose.
        for (int k = 0; k < 16; k++)
            pool_start[k] = rand64() | 64'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_invalid_arguments();
        test_overlap_priority();
        wait_for_replies(0);
        test_address_extremes();
        test_table_full();
        wait_for_replies(0);
        test_random_traffic(280, 55, 10);
        test_random_traffic(240, 30, 30);
        wait_for_replies(0);
        test_random_traffic(240, 10, 55);
        wait_for_replies(REPLY_LATENCY + 10);

        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/arrl_pkg.sv
rtl/arrl_ctrl.sv
rtl/arrl_datapath.sv
rtl/address_range_reverse_lookup.sv
tb/address_range_reverse_lookup_tb.sv
